@@ rtl/csu_pkg.sv @@
// csu_pkg: shared types and constants of the counting semaphore unit
// command and status codes, controller states, control and status bundles
// no dependencies
package csu_pkg;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 6;
  localparam int PID_W    = 5;
  localparam int AIDX_W   = 5;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 16;

  localparam logic [CFG_W-1:0] INIT_COUNT_RESET = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT = 2'd0,
    CMD_WAIT = 2'd1,
    CMD_POST = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE        = 3'd0,
    STS_BLOCKED     = 3'd1,
    STS_WOKEN       = 3'd2,
    STS_BAD_INDEX   = 3'd3,
    STS_UNINIT      = 3'd4,
    STS_POOL_EMPTY  = 3'd5,
    STS_QUEUE_FULL  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_WAKE,
    S_EMIT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic wake_rd;
    logic wake_wr;
    logic load_out;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_wake;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/csu_ram.sv @@
// csu_ram: generic single write port, single read port ram
// read data is registered and updates only when re is high
// no dependencies
module csu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/csu_ctrl.sv @@
// csu_ctrl: controller state machine of the counting semaphore unit
// sequences lookup, optional waiter read and result hand-off
// depends on csu_pkg
module csu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csu_pkg::dp_stat_t     stat,
  output csu_pkg::ctrl_cmd_t    ctl
);
  import csu_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LOOK;
      S_LOOK: state_next = stat.need_wake ? S_WAKE : S_EMIT;
      S_WAKE: state_next = S_EMIT;
      S_EMIT: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      S_LOOK: begin
        ctl.exec    = !stat.need_wake;
        ctl.wake_rd = stat.need_wake;
      end
      S_WAKE: begin
        ctl.wake_wr = 1'b1;
      end
      S_EMIT: begin
        ctl.load_out = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/csu_datapath.sv @@
// csu_datapath: request registers, semaphore table, wait queues and output register
// semaphore entries and queued pids live in csu_ram instances
// depends on csu_pkg and csu_ram
module csu_datapath #(
  parameter int SEM_COUNT  = 32,
  parameter int WAIT_DEPTH = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [csu_pkg::CFG_W-1:0]     cfg_data,
  input  logic [csu_pkg::CMD_W-1:0]     cmd,
  input  logic [csu_pkg::IDX_W-1:0]     sem_id,
  input  logic [csu_pkg::PID_W-1:0]     caller_pid,
  input  logic                          out_ready,
  input  csu_pkg::ctrl_cmd_t            ctl,
  output csu_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output logic [csu_pkg::STATUS_W-1:0]  status,
  output logic [csu_pkg::AIDX_W-1:0]    assigned_index,
  output logic [csu_pkg::PID_W-1:0]     woken_pid
);
  import csu_pkg::*;

  localparam int SI_W     = $clog2(SEM_COUNT);
  localparam int HEAD_W   = $clog2(WAIT_DEPTH);
  localparam int FILL_W   = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W    = FILL_W + 1;
  localparam int NF_W     = $clog2(SEM_COUNT + 1);
  localparam int ENT_W    = COUNT_BITS + HEAD_W + FILL_W;
  localparam int WQ_AW    = SI_W + HEAD_W;
  localparam int WQ_DEPTH = SEM_COUNT << HEAD_W;
  localparam logic [32:0] CNT_LIM = (33'd1 << COUNT_BITS) - 33'd1;

  // request and configuration registers
  cmd_t                req_cmd;
  logic [IDX_W-1:0]    req_idx;
  logic [PID_W-1:0]    req_pid;
  logic [CFG_W-1:0]    init_cnt;
  logic [NF_W-1:0]     next_free;
  logic [SEM_COUNT-1:0] sem_ready;

  // result waiting for the output register
  status_t             res_status;
  logic [AIDX_W-1:0]   res_index;
  logic [PID_W-1:0]    res_pid;

  // ram ports
  logic [ENT_W-1:0]    ent_rd, ent_wr;
  logic                sem_we;
  logic [SI_W-1:0]     sem_waddr;
  logic [PID_W-1:0]    wq_rd;
  logic                wq_we;

  // entry fields and decisions
  logic [SI_W-1:0]       sel;
  logic [COUNT_BITS-1:0] cnt, cnt_init, w_cnt;
  logic [HEAD_W-1:0]     head, head_inc, tail, w_head;
  logic [FILL_W-1:0]     fill, w_fill;
  logic [SUM_W-1:0]      tail_sum;
  logic                  in_range, is_ready, pool_empty, q_full, q_any, alloc, blk;
  status_t               r_status;
  logic [AIDX_W-1:0]     r_index;

  assign cnt  = ent_rd[ENT_W-1 -: COUNT_BITS];
  assign head = ent_rd[FILL_W +: HEAD_W];
  assign fill = ent_rd[FILL_W-1:0];

  assign sel        = SI_W'(req_idx);
  assign in_range   = 32'(req_idx) < 32'(SEM_COUNT);
  assign is_ready   = in_range && sem_ready[sel];
  assign pool_empty = next_free == NF_W'(SEM_COUNT);
  assign q_full     = fill == FILL_W'(WAIT_DEPTH);
  assign q_any      = fill != '0;

  // queue slot after the last waiter, head + fill wrapped once
  assign tail_sum = SUM_W'(head) + SUM_W'(fill);
  assign tail     = (tail_sum >= SUM_W'(WAIT_DEPTH)) ?
                    HEAD_W'(tail_sum - SUM_W'(WAIT_DEPTH)) : HEAD_W'(tail_sum);
  assign head_inc = (head == HEAD_W'(WAIT_DEPTH - 1)) ? '0 : head + 1'b1;

  // initial count clipped to the count width
  assign cnt_init = (33'(init_cnt) > CNT_LIM) ? CNT_LIM[COUNT_BITS-1:0]
                                              : COUNT_BITS'(init_cnt);

  assign stat.need_wake = (req_cmd == CMD_POST) && is_ready && q_any;
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    r_status  = STS_DONE;
    r_index   = req_idx[AIDX_W-1:0];
    sem_we    = 1'b0;
    sem_waddr = sel;
    w_cnt     = cnt;
    w_head    = head;
    w_fill    = fill;
    alloc     = 1'b0;
    blk       = 1'b0;
    unique case (req_cmd) inside
      CMD_INIT: begin
        if (!is_ready) begin
          if (pool_empty) begin
            r_status = STS_POOL_EMPTY;
          end else begin
            alloc     = 1'b1;
            sem_we    = 1'b1;
            sem_waddr = SI_W'(next_free);
            w_cnt     = cnt_init;
            w_head    = '0;
            w_fill    = '0;
            r_index   = AIDX_W'(next_free);
          end
        end
      end
      CMD_WAIT, CMD_POST: begin
        if (!in_range) begin
          r_status = STS_BAD_INDEX;
        end else if (!is_ready) begin
          r_status = STS_UNINIT;
        end else if (req_cmd == CMD_WAIT) begin
          if (cnt != '0) begin
            sem_we = 1'b1;
            w_cnt  = cnt - 1'b1;
          end else if (q_full) begin
            r_status = STS_QUEUE_FULL;
          end else begin
            blk      = 1'b1;
            sem_we   = 1'b1;
            w_fill   = fill + 1'b1;
            r_status = STS_BLOCKED;
          end
        end else begin
          // post with no waiter, count saturates
          sem_we = 1'b1;
          if (!(&cnt)) w_cnt = cnt + 1'b1;
        end
      end
      default: begin
        r_status = STS_DONE;
      end
    endcase
    if (ctl.wake_wr) begin
      sem_waddr = sel;
      w_cnt     = cnt;
      w_head    = head_inc;
      w_fill    = fill - 1'b1;
    end
  end

  assign ent_wr = {w_cnt, w_head, w_fill};
  assign wq_we  = ctl.exec && blk;

  csu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SEM_COUNT)
  ) u_sem_ram (
    .clk   (clk),
    .we    ((ctl.exec && sem_we) || ctl.wake_wr),
    .waddr (sem_waddr),
    .wdata (ent_wr),
    .re    (ctl.capture),
    .raddr (SI_W'(sem_id)),
    .rdata (ent_rd)
  );

  csu_ram #(
    .WIDTH (PID_W),
    .DEPTH (WQ_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (wq_we),
    .waddr (WQ_AW'({sel, tail})),
    .wdata (req_pid),
    .re    (ctl.wake_rd),
    .raddr (WQ_AW'({sel, head})),
    .rdata (wq_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt  <= INIT_COUNT_RESET;
      next_free <= '0;
      sem_ready <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) init_cnt <= cfg_data;
      if (ctl.exec && alloc) begin
        next_free                   <= next_free + 1'b1;
        sem_ready[SI_W'(next_free)] <= 1'b1;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd <= cmd_t'(cmd);
      req_idx <= sem_id;
      req_pid <= caller_pid;
    end
    if (ctl.exec) begin
      res_status <= r_status;
      res_index  <= r_index;
      res_pid    <= '0;
    end else if (ctl.wake_wr) begin
      res_status <= STS_WOKEN;
      res_index  <= req_idx[AIDX_W-1:0];
      res_pid    <= wq_rd;
    end
    if (ctl.load_out) begin
      status         <= res_status;
      assigned_index <= res_index;
      woken_pid      <= res_pid;
    end
  end

endmodule

@@ rtl/counting_semaphore_unit_top.sv @@
// counting_semaphore_unit_top: top level of the hardware semaphore bank
// joins the controller and the datapath
// depends on csu_pkg, csu_ctrl, csu_datapath
//
// usage
//   request channel: in_valid/in_ready with cmd, sem_id, caller_pid
//   result channel: out_valid/out_ready with status, assigned_index, woken_pid
//   cfg_write/cfg_data load initial_count at any edge, no handshake
// one request is worked at a time: lookup of the semaphore entry in the
// table ram, a read of the oldest waiter when a post wakes one,
// then the result moves into the output register
// the table read is registered at accept, then the entry update (after the
// waiter read for a wake) and the output load follow; a new word is taken
// only once the result of the last one has gone into the output register
// a result held in the output register does not block the next request;
// that request waits in the controller until the receiver takes the word
// reset clears the pool pointer, the initialized flags and the output valid;
// initial_count returns to 1, the table needs no clearing pass
module counting_semaphore_unit_top #(
  parameter int SEM_COUNT  = 32,
  parameter int WAIT_DEPTH = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [csu_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csu_pkg::CMD_W-1:0]     cmd,
  input  logic [csu_pkg::IDX_W-1:0]     sem_id,
  input  logic [csu_pkg::PID_W-1:0]     caller_pid,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csu_pkg::STATUS_W-1:0]  status,
  output logic [csu_pkg::AIDX_W-1:0]    assigned_index,
  output logic [csu_pkg::PID_W-1:0]     woken_pid
);
  import csu_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  csu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  csu_datapath #(
    .SEM_COUNT  (SEM_COUNT),
    .WAIT_DEPTH (WAIT_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sem_id         (sem_id),
    .caller_pid     (caller_pid),
    .out_ready      (out_ready),
    .ctl            (ctl),
    .stat           (stat),
    .out_valid      (out_valid),
    .status         (status),
    .assigned_index (assigned_index),
    .woken_pid      (woken_pid)
  );

endmodule

@@ rtl/csu_checker.sv @@
// csu_checker: port level checks of the counting semaphore unit
// bound to counting_semaphore_unit_top
// depends on csu_pkg
module csu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [csu_pkg::STATUS_W-1:0]  status,
  input logic [csu_pkg::AIDX_W-1:0]    assigned_index,
  input logic [csu_pkg::PID_W-1:0]     woken_pid
);
  import csu_pkg::*;

  // after reset the block is empty and open for a request
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  // one request at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // only a wake reports a pid
  a_pid_only_on_wake: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STS_WOKEN)) |-> (woken_pid == '0))
    else $error("woken pid set without a wake");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(assigned_index) && $stable(woken_pid)))
    else $error("result word changed while stalled");

endmodule

bind counting_semaphore_unit_top csu_checker u_csu_checker (.*);
